FILE: sv/hbm_pkg.sv
// Heartbeat monitor package: command and register codes, reset values and
// the command and configuration records shared by the monitor's modules.
// No dependencies.
package hbm_pkg;

  // Command codes on the input channel
  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_PONG     = 2'd1;
  localparam logic [1:0] CMD_ANNOUNCE = 2'd2;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_DEFAULT_PORT = 2'd0;
  localparam logic [1:0] REG_TIMEOUT      = 2'd1;
  localparam logic [1:0] REG_PING_ALL     = 2'd2;

  // Configuration reset values
  localparam logic [15:0] DEFAULT_PORT_RESET = 16'd0;
  localparam logic [15:0] TIMEOUT_RESET      = 16'd15;
  localparam logic [15:0] PING_ALL_RESET     = 16'd60;

  // Classified command as it travels from the front end to the table engine
  typedef struct packed {
    logic [1:0]  cmd;
    logic        ping_all;
    logic [31:0] now;
    logic [31:0] addr;
    logic [15:0] port;
  } cmd_t;

  // Configuration registers
  typedef struct packed {
    logic [15:0] default_port;
    logic [15:0] timeout_seconds;
    logic [15:0] ping_all_period;
  } cfg_t;

endpackage

FILE: sv/hbm_ifs.sv
// Valid/ready channel interfaces of the heartbeat monitor: event input and
// ping request output. No dependencies.
interface hbm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] now_seconds;
  logic [31:0] peer_addr;
  logic [15:0] peer_port;

  modport source(output valid, command, now_seconds, peer_addr, peer_port, input ready);
  modport sink(input valid, command, now_seconds, peer_addr, peer_port, output ready);
endinterface

interface hbm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] ping_addr;
  logic [15:0] ping_port;
  logic        last_of_run;

  modport source(output valid, ping_addr, ping_port, last_of_run, input ready);
  modport sink(input valid, ping_addr, ping_port, last_of_run, output ready);
endinterface

FILE: sv/hbm_front.sv
// Front end of the heartbeat monitor: accepts events, drops unused commands,
// decides ping-all on ticks and pushes classified commands. Uses hbm_pkg, hbm_ifs.
module hbm_front (
  input  logic            clk,
  input  logic            rst_n,
  hbm_in_if.sink          in_ch,
  input  hbm_pkg::cfg_t   cfg,
  input  logic            q_full,
  output logic            q_push,
  output hbm_pkg::cmd_t   q_data
);
  import hbm_pkg::*;

  logic [31:0] last_all_r, last_all_nxt;
  logic        accept;
  logic        ping_all;

  // Take a beat whenever the queue has room
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  // Ping-all when the elapsed time since the last one exceeds the period
  assign ping_all = (in_ch.now_seconds - last_all_r) > {16'd0, cfg.ping_all_period};

  always_comb begin
    q_data.cmd      = in_ch.command;
    q_data.ping_all = ping_all;
    q_data.now      = in_ch.now_seconds;
    q_data.addr     = in_ch.peer_addr;
    q_data.port     = in_ch.peer_port;
  end

  // Drop unused commands here
  assign q_push = accept && (in_ch.command != CMD_UNUSED);

  // Stamp the ping-all time on a tick that pings everyone
  always_comb begin
    last_all_nxt = last_all_r;
    if (accept && (in_ch.command == CMD_TICK) && ping_all) begin
      last_all_nxt = in_ch.now_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_all_r <= 32'd0;
    end else begin
      last_all_r <= last_all_nxt;
    end
  end

endmodule

FILE: sv/hbm_fifo.sv
// Two-entry command queue between the front end and the table engine.
// Uses hbm_pkg.
module hbm_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hbm_pkg::cmd_t   push_data,
  output logic            full,
  output logic            valid,
  output hbm_pkg::cmd_t   pop_data,
  input  logic            pop
);
  import hbm_pkg::*;

  cmd_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign valid    = (cnt_r != 2'd0);
  assign pop_data = entry_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold the payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: sv/hbm_back.sv
// Table engine of the heartbeat monitor: holds the peer table and walks it
// newest first for ticks, pongs and announcements. Uses hbm_pkg, hbm_ifs.
module hbm_back #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  hbm_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  hbm_pkg::cmd_t   q_data,
  output logic            q_pop,
  hbm_out_if.source       out_ch
);
  import hbm_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  // Peer table memories
  logic [47:0] ap_mem   [TABLE_DEPTH];
  logic [31:0] seen_mem [TABLE_DEPTH];

  logic [1:0]             state_r, state_nxt;
  cmd_t                   cur_r, cur_nxt;
  logic [IW-1:0]          ev_k_r, ev_k_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [TABLE_DEPTH-1:0] online_r, online_nxt;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [31:0]   addr_q, seen_q;
  logic [15:0]   port_q;

  logic          ap_we, seen_we;
  logic [IW-1:0] wr_idx;
  logic [31:0]   ap_addr;

  logic          pend_v_r, pend_v_nxt;
  logic [31:0]   pend_addr_r, pend_addr_nxt;
  logic [15:0]   pend_port_r, pend_port_nxt;

  logic          out_v_r, out_last_r, out_last_nxt;
  logic [31:0]   out_addr_r, out_addr_nxt;
  logic [15:0]   out_port_r, out_port_nxt;
  logic          out_push, out_free;

  logic          online, is_last, ping, timed_out, has_room;

  assign out_free  = !out_v_r || out_ch.ready;
  assign online    = online_r[ev_k_r];
  assign is_last   = (ev_k_r == '0);
  assign ping      = !online || cur_r.ping_all;
  assign timed_out = (cur_r.now - seen_q) > {16'd0, cfg.timeout_seconds};
  assign has_room  = (count_r < CW'(TABLE_DEPTH));

  // Sequence the walk over the table
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    ev_k_nxt      = ev_k_r;
    count_nxt     = count_r;
    online_nxt    = online_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = ev_k_r - IW'(1);
    ap_we         = 1'b0;
    seen_we       = 1'b0;
    wr_idx        = ev_k_r;
    ap_addr       = cur_r.addr;
    pend_v_nxt    = pend_v_r;
    pend_addr_nxt = pend_addr_r;
    pend_port_nxt = pend_port_r;
    out_push      = 1'b0;
    out_addr_nxt  = pend_addr_r;
    out_port_nxt  = pend_port_r;
    out_last_nxt  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_data;
          if (count_r == '0) begin
            // Empty table: only an announcement has an effect
            if (q_data.cmd == CMD_ANNOUNCE) begin
              ap_we     = 1'b1;
              wr_idx    = '0;
              ap_addr   = q_data.addr;
              count_nxt = count_r + CW'(1);
            end
          end else begin
            rd_en     = 1'b1;
            rd_addr   = IW'(count_r - CW'(1));
            ev_k_nxt  = IW'(count_r - CW'(1));
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        case (cur_r.cmd)
          CMD_TICK: begin
            // Stall when a finished ping cannot leave
            if (!(ping && pend_v_r && !out_free)) begin
              if (ping) begin
                pend_v_nxt    = 1'b1;
                pend_addr_nxt = addr_q;
                pend_port_nxt = port_q;
                out_push      = pend_v_r;
              end
              if (online && timed_out) begin
                online_nxt[ev_k_r] = 1'b0;
              end
              if (is_last) begin
                state_nxt = (ping || pend_v_r) ? ST_FLUSH : ST_IDLE;
              end else begin
                rd_en    = 1'b1;
                ev_k_nxt = ev_k_r - IW'(1);
              end
            end
          end
          CMD_PONG: begin
            if ((addr_q == cur_r.addr) && (port_q == cur_r.port)) begin
              seen_we            = 1'b1;
              online_nxt[ev_k_r] = 1'b1;
              state_nxt          = ST_IDLE;
            end else if (is_last) begin
              state_nxt = ST_IDLE;
            end else begin
              rd_en    = 1'b1;
              ev_k_nxt = ev_k_r - IW'(1);
            end
          end
          CMD_ANNOUNCE: begin
            if (addr_q == cur_r.addr) begin
              state_nxt = ST_IDLE;
            end else if (is_last) begin
              // New address: append when there is room
              if (has_room) begin
                ap_we     = 1'b1;
                wr_idx    = IW'(count_r);
                count_nxt = count_r + CW'(1);
              end
              state_nxt = ST_IDLE;
            end else begin
              rd_en    = 1'b1;
              ev_k_nxt = ev_k_r - IW'(1);
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_FLUSH: begin
        // Release the final ping of the tick
        if (out_free) begin
          out_push     = 1'b1;
          out_last_nxt = 1'b1;
          pend_v_nxt   = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      online_r <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      online_r <= online_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_push || (out_v_r && !out_ch.ready);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    ev_k_r      <= ev_k_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_port_r <= pend_port_nxt;
    if (out_push) begin
      out_addr_r <= out_addr_nxt;
      out_port_r <= out_port_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  // Table memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (ap_we) begin
      ap_mem[wr_idx] <= {ap_addr, cfg.default_port};
    end
    if (rd_en) begin
      {addr_q, port_q} <= ap_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (seen_we) begin
      seen_mem[wr_idx] <= cur_r.now;
    end
    if (rd_en) begin
      seen_q <= seen_mem[rd_addr];
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.ping_addr   = out_addr_r;
  assign out_ch.ping_port   = out_port_r;
  assign out_ch.last_of_run = out_last_r;

endmodule

FILE: sv/peer_heartbeat_monitor.sv
// Peer heartbeat monitor top level: configuration registers, front end,
// command queue and table engine. Uses hbm_pkg, hbm_ifs, hbm_front, hbm_fifo, hbm_back.
//
// Tracks up to TABLE_DEPTH peers. A service tick (command 0) walks the table
// newest first and emits one ping request per offline peer, or per peer when
// the ping-all period has run out, flagging the final one with last_of_run;
// online peers whose last pong is older than timeout_seconds go offline. A
// pong (command 1) marks the newest peer with matching address and port
// online; an announcement (command 2) appends a new address at default_port.
// Events pass through a two-entry queue, so the input keeps accepting while
// the table engine works, until the queue is full. The engine reads one
// table entry per cycle unless a ping cannot leave, takes the next event
// only when idle, releasing a tick's final ping from a flush state. The user
// must write configuration only while the block is idle; it is not enforced.
module peer_heartbeat_monitor #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  hbm_in_if.sink      in_ch,
  hbm_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import hbm_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic q_full, q_push, q_valid, q_pop;
  cmd_t q_wdata, q_rdata;

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_DEFAULT_PORT: cfg_nxt.default_port    = cfg_wdata;
        REG_TIMEOUT:      cfg_nxt.timeout_seconds = cfg_wdata;
        REG_PING_ALL:     cfg_nxt.ping_all_period = cfg_wdata;
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.default_port    <= DEFAULT_PORT_RESET;
      cfg_r.timeout_seconds <= TIMEOUT_RESET;
      cfg_r.ping_all_period <= PING_ALL_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hbm_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  hbm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .valid     (q_valid),
    .pop_data  (q_rdata),
    .pop       (q_pop)
  );

  hbm_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: sv/hbm_check.sv
// Port checker for the peer heartbeat monitor, bound to the top level.
// Depends on peer_heartbeat_monitor and hbm_ifs.
module hbm_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_ping_addr,
  input logic [15:0] out_ping_port,
  input logic        out_last_of_run
);

  // Hold a stalled ping request
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ping_addr) &&
      $stable(out_ping_port) && $stable(out_last_of_run))
    else $error("stalled ping request changed");

  // Drop any pending request on reset
  a_out_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("ping request valid after reset");

  // Come out of reset with an empty queue
  a_in_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind peer_heartbeat_monitor hbm_check u_hbm_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_ping_addr   (out_ch.ping_addr),
  .out_ping_port   (out_ch.ping_port),
  .out_last_of_run (out_ch.last_of_run)
);
